// File: rtl/core/cdg_pkg.sv
// Shared types, constants and arithmetic helpers for the cosine and decay generator.
// No dependencies; every other file refers to it by scoped names.
package cdg_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned PhaseW   = 32;

  localparam logic [15:0] CountReset = 16'd101;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE         = 3'd0,
    REG_AMPLITUDE    = 3'd1,
    REG_PHASE_STEP   = 3'd2,
    REG_PHASE_OFFSET = 3'd3,
    REG_DECAY_RATIO  = 3'd4,
    REG_SAMPLE_COUNT = 3'd5
  } reg_idx_e;

  // Output select: 0 cosine, 1 exponential decay
  localparam logic ModeDecay = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [SampleW-1:0] amplitude;
    logic [PhaseW-1:0]         phase_step;
    logic [PhaseW-1:0]         phase_offset;
    logic [15:0]               decay_ratio;
    logic [15:0]               sample_count;
  } cfg_t;

  // Per-sample side information carried down the pipeline
  typedef struct packed {
    logic signed [SampleW-1:0] level;
    logic [15:0]               index;
    logic                      last;
  } samp_t;

  // Saturate to signed 16 bits
  function automatic logic signed [SampleW-1:0] sat16(input logic signed [33:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // (a * b + 2^14) >>> 15, saturated; Q1.15 times Q1.15
  function automatic logic signed [SampleW-1:0] mul_q15(input logic signed [15:0] a,
                                                         input logic signed [15:0] b);
    logic signed [32:0] ax;
    logic signed [32:0] bx;
    logic signed [32:0] p;
    logic signed [32:0] s;
    logic signed [32:0] r;
    ax = 33'(a);
    bx = 33'(b);
    p  = ax * bx;
    s  = p + 33'sd16384;
    r  = s >>> 15;
    return sat16(34'(r));
  endfunction

  // (level * ratio + 2^15) >>> 16, saturated; ratio is unsigned Q0.16
  function automatic logic signed [SampleW-1:0] decay_q16(input logic signed [15:0] level,
                                                           input logic [15:0] ratio);
    logic signed [33:0] lx;
    logic signed [33:0] rx;
    logic signed [33:0] p;
    logic signed [33:0] s;
    logic signed [33:0] r;
    lx = 34'(level);
    rx = 34'($signed({1'b0, ratio}));
    p  = lx * rx;
    s  = p + 34'sd32768;
    r  = s >>> 16;
    return sat16(r);
  endfunction

  // 32767 * cos(pi/2 * m / 2^qbits), Q30 Taylor series; elaboration only
  function automatic logic signed [15:0] quarter_cos(input int unsigned m,
                                                     input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] su;
    logic [63:0] scaled;
    longint      sum;
    x    = ((64'd1686629713 * 64'(m)) + ((64'd1 << qbits) >> 1)) >> qbits;
    x2   = (x * x + 64'd536870912) >> 30;
    term = 64'd1073741824;
    sum  = 64'sd1073741824;
    term = ((term * x2) >> 30) / 64'd2;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd12;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd30;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd56;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd90;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd132; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd182; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd240; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd306; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd380; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd462; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd552; sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    su     = sum;
    scaled = (su * 64'd32767 + 64'd536870912) >> 30;
    return scaled[15:0];
  endfunction

  // Full-cycle cosine word k of a 2^abits table, built from the quarter wave
  function automatic logic signed [15:0] cos_word(input int unsigned k,
                                                  input int unsigned abits);
    int unsigned       qbits;
    int unsigned       quarter;
    int unsigned       j;
    int unsigned       m;
    logic [1:0]        quad;
    logic signed [15:0] v;
    qbits   = abits - 2;
    quarter = 1 << qbits;
    quad    = 2'(k >> qbits);
    j       = k & (quarter - 1);
    // second and fourth quadrants read the quarter wave backwards
    m       = quad[0] ? (quarter - j) : j;
    v       = quarter_cos(m, qbits);
    // second and third quadrants are negative
    return (quad[1] ^ quad[0]) ? -v : v;
  endfunction

endpackage

// File: rtl/core/cdg_cfg_regs.sv
// Configuration register file of the cosine and decay generator.
// Depends on cdg_pkg for the register index codes and the cfg_t layout.
module cdg_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cdg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cdg_pkg::CfgDataW-1:0] cfg_data_i,
  output cdg_pkg::cfg_t                cfg_o
);

  cdg_pkg::cfg_t cfg_q;

  // Write-only registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= 1'b0;
      cfg_q.amplitude    <= '0;
      cfg_q.phase_step   <= '0;
      cfg_q.phase_offset <= '0;
      cfg_q.decay_ratio  <= '0;
      cfg_q.sample_count <= cdg_pkg::CountReset;
    end else if (cfg_we_i) begin
      case (cdg_pkg::reg_idx_e'(cfg_idx_i))
        cdg_pkg::REG_MODE:         cfg_q.mode         <= cfg_data_i[0];
        cdg_pkg::REG_AMPLITUDE:    cfg_q.amplitude    <= cfg_data_i[15:0];
        cdg_pkg::REG_PHASE_STEP:   cfg_q.phase_step   <= cfg_data_i[31:0];
        cdg_pkg::REG_PHASE_OFFSET: cfg_q.phase_offset <= cfg_data_i[31:0];
        cdg_pkg::REG_DECAY_RATIO:  cfg_q.decay_ratio  <= cfg_data_i[15:0];
        cdg_pkg::REG_SAMPLE_COUNT: cfg_q.sample_count <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/cdg_cos_rom.sv
// Full-cycle cosine ROM with registered read, contents built at elaboration.
// Depends on cdg_pkg::cos_word for the table values.
module cdg_cos_rom #(
  parameter int unsigned AddrBits = 10
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [AddrBits-1:0] addr_i,
  output logic signed [15:0]  data_o
);

  localparam int unsigned Depth = 1 << AddrBits;

  logic signed [15:0] rom [Depth];
  logic signed [15:0] data_q;

  // Constant contents
  for (genvar k = 0; k < Depth; k++) begin : g_rom
    assign rom[k] = cdg_pkg::cos_word(k, AddrBits);
  end

  // Registered read, held while the stage stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= rom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

// File: rtl/core/cdg_seq.sv
// Sequence state (position, phase accumulator, decay level) and first pipeline stage.
// Depends on cdg_pkg for cfg_t, samp_t and the decay arithmetic.
module cdg_seq #(
  parameter int unsigned AddrBits = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cdg_pkg::cfg_t       cfg_i,
  input  logic                valid_i,
  input  logic                restart_i,
  input  logic                ld_en_i,
  output logic                s1_valid_o,
  output logic [AddrBits-1:0] s1_addr_o,
  output cdg_pkg::samp_t      s1_samp_o
);

  localparam int unsigned PhaseW = cdg_pkg::PhaseW;

  logic [15:0]                       pos_q;
  logic [PhaseW-1:0]                 acc_q;
  logic signed [cdg_pkg::SampleW-1:0] lvl_q;

  logic                              s1_valid_q;
  logic [AddrBits-1:0]               s1_addr_q;
  cdg_pkg::samp_t                    s1_samp_q;

  logic                              accept;
  logic [15:0]                       pos_cur;
  logic [PhaseW-1:0]                 acc_cur;
  logic signed [cdg_pkg::SampleW-1:0] lvl_cur;
  logic [15:0]                       count_m1;
  logic                              last;
  logic [PhaseW-1:0]                 phase;

  assign accept = valid_i && ld_en_i;

  // Restart clears the sequence before this sample
  assign pos_cur = restart_i ? '0 : pos_q;
  assign acc_cur = restart_i ? '0 : acc_q;
  assign lvl_cur = restart_i ? cfg_i.amplitude : lvl_q;

  // A count of zero behaves as one
  assign count_m1 = (cfg_i.sample_count == '0) ? '0 : cfg_i.sample_count - 16'd1;
  assign last     = pos_cur >= count_m1;

  assign phase = acc_cur + cfg_i.phase_offset;

  // Sequence state update per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      acc_q <= '0;
      lvl_q <= '0;
    end else if (accept) begin
      if (last) begin
        pos_q <= '0;
        acc_q <= '0;
        lvl_q <= cfg_i.amplitude;
      end else begin
        pos_q <= pos_cur + 16'd1;
        acc_q <= acc_cur + cfg_i.phase_step;
        lvl_q <= cdg_pkg::decay_q16(lvl_cur, cfg_i.decay_ratio);
      end
    end
  end

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ld_en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  // Stage 1 payload: ROM address and side data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q       <= phase[PhaseW-1 -: AddrBits];
      s1_samp_q.level <= lvl_cur;
      s1_samp_q.index <= pos_cur;
      s1_samp_q.last  <= last;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_addr_o  = s1_addr_q;
  assign s1_samp_o  = s1_samp_q;

`ifndef SYNTHESIS
  a_restart_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && restart_i) |=> (s1_samp_q.index == '0))
    else $error("restart did not start at sample zero");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !restart_i && !last) |=> (pos_q == $past(pos_q) + 16'd1))
    else $error("position did not advance by one");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (pos_q == '0 && acc_q == '0 && lvl_q == $past(cfg_i.amplitude)))
    else $error("sequence did not wrap after last sample");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !ld_en_i) |=> (s1_valid_q && $stable(s1_addr_q)))
    else $error("stage 1 lost its transaction while stalled");
`endif

endmodule

// File: rtl/core/cdg_out.sv
// ROM-aligned stage and output register: amplitude scaling and mode select.
// Depends on cdg_pkg for cfg_t, samp_t and the Q1.15 multiply helper.
module cdg_out (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cdg_pkg::cfg_t                      cfg_i,
  input  logic                               s1_valid_i,
  input  cdg_pkg::samp_t                     s1_samp_i,
  input  logic signed [cdg_pkg::SampleW-1:0] rom_word_i,
  output logic                               s2_en_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [cdg_pkg::SampleW-1:0] value_o,
  output logic [15:0]                        index_o,
  output logic                               last_o
);

  logic                               s2_valid_q;
  cdg_pkg::samp_t                     s2_samp_q;
  logic                               out_valid_q;
  logic signed [cdg_pkg::SampleW-1:0] value_q;
  logic [15:0]                        index_q;
  logic                               last_q;
  logic                               out_en;
  logic                               s2_en;

  // Each stage loads when empty or when its successor moves
  assign out_en = !out_valid_q || out_ready_i;
  assign s2_en  = !s2_valid_q || out_en;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_en) begin
        s2_valid_q <= s1_valid_i;
      end
      if (out_en) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Stage 2 side data, aligned with the ROM read
  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_i) begin
      s2_samp_q <= s1_samp_i;
    end
  end

  // Output register: scaled cosine or decay level
  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      value_q <= (cfg_i.mode == cdg_pkg::ModeDecay) ? s2_samp_q.level
                                                    : cdg_pkg::mul_q15(cfg_i.amplitude,
                                                                       rom_word_i);
      index_q <= s2_samp_q.index;
      last_q  <= s2_samp_q.last;
    end
  end

  assign s2_en_o     = s2_en;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign index_o     = index_q;
  assign last_o      = last_q;

endmodule

// File: rtl/core/cosine_and_decay_generator.sv
// Cosine / exponential-decay sample generator, one sample per input transaction.
// An accepted transaction passes the stage 1, ROM read and output registers to the output port.
// Throughput: one sample per cycle while m_axis_tready is high; stages are address/state, ROM read, scaling.
// Reset (async, active low) clears the sequence state and pipeline valids and
// loads configuration defaults; the cosine ROM is constant and needs no clearing.
// Depends on cdg_pkg, cdg_cfg_regs, cdg_seq, cdg_cos_rom and cdg_out.
module cosine_and_decay_generator #(
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write port
  input  logic                         cfg_we_i,
  input  logic [cdg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cdg_pkg::CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [0] restart, [7:1] zero
  // sample stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // [15:0] sample_value, [31:16] sample_index
  output logic                         m_axis_tlast   // last_sample
);

  cdg_pkg::cfg_t                      cfg;
  logic                               s1_valid;
  logic [TABLE_ADDR_BITS-1:0]         s1_addr;
  cdg_pkg::samp_t                     s1_samp;
  logic                               s1_en;
  logic                               s2_en;
  logic signed [cdg_pkg::SampleW-1:0] rom_word;
  logic signed [cdg_pkg::SampleW-1:0] value;
  logic [15:0]                        index;

  cdg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stage 1 loads when empty or when stage 2 moves
  assign s1_en         = !s1_valid || s2_en;
  assign s_axis_tready = s1_en;

  cdg_seq #(
    .AddrBits (TABLE_ADDR_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .valid_i    (s_axis_tvalid),
    .restart_i  (s_axis_tdata[0]),
    .ld_en_i    (s1_en),
    .s1_valid_o (s1_valid),
    .s1_addr_o  (s1_addr),
    .s1_samp_o  (s1_samp)
  );

  cdg_cos_rom #(
    .AddrBits (TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (s2_en && s1_valid),
    .addr_i (s1_addr),
    .data_o (rom_word)
  );

  cdg_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .s1_valid_i  (s1_valid),
    .s1_samp_i   (s1_samp),
    .rom_word_i  (rom_word),
    .s2_en_o     (s2_en),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .value_o     (value),
    .index_o     (index),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {index, value};

endmodule
